/* rtl/bspq_pkg.sv */
// shared types, constants and codes for the bounded sorted priority queue
`timescale 1ns / 1ps

package bspq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIMIT_W = 5;
    localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
    localparam int VALUE_W = 32;
    localparam int PRIO_W = 8;
    localparam int OCC_W = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
    localparam logic signed [VALUE_W-1:0] MOST_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                        operation;
        logic signed [VALUE_W-1:0]  item_value;
        logic [PRIO_W-1:0]          item_priority;
    } req_t;

    typedef struct packed
    {
        status_t                    status;
        logic signed [VALUE_W-1:0]  head_value;
        logic [OCC_W-1:0]           occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed
    {
        logic capture;
        logic enq;
        logic deq;
        logic overflow;
        logic underflow;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic full;
        logic empty;
    } dp_status_t;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

endpackage

/* rtl/bspq_ctrl.sv */
// controller: request handshake, operation decode and result hand-off
`timescale 1ns / 1ps

module bspq_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  bspq_pkg::op_t         operation,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  bspq_pkg::dp_status_t  dp_status,
    output bspq_pkg::dp_cmd_t     dp_cmd
);

    bspq_pkg::state_t state_reg;
    bspq_pkg::state_t state_next;
    logic             accept;

    assign accept    = req_valid && (state_reg == bspq_pkg::S_IDLE);
    assign req_stall = (state_reg != bspq_pkg::S_IDLE);
    assign rsp_valid = (state_reg == bspq_pkg::S_RESP);

    always_comb
    begin
        dp_cmd.capture   = accept;
        dp_cmd.overflow  = accept && (operation == bspq_pkg::OP_ENQUEUE) && dp_status.full;
        dp_cmd.underflow = accept && (operation == bspq_pkg::OP_DEQUEUE) && dp_status.empty;
        dp_cmd.enq       = accept && (operation == bspq_pkg::OP_ENQUEUE) && !dp_status.full;
        dp_cmd.deq       = accept && (operation == bspq_pkg::OP_DEQUEUE) && !dp_status.empty;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bspq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bspq_pkg::S_RESP;
                end
            end
            bspq_pkg::S_RESP:
            begin
                // result transfer frees the block for the next request
                if (!rsp_stall)
                begin
                    state_next = bspq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bspq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bspq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/bspq_datapath.sv */
// datapath: row of compare-and-shift slots, entry count, limit and result register
`timescale 1ns / 1ps

module bspq_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [bspq_pkg::LIMIT_W-1:0]           cfg_data,
    input  bspq_pkg::req_t                         req,
    input  bspq_pkg::dp_cmd_t                      dp_cmd,
    output bspq_pkg::dp_status_t                   dp_status,
    output bspq_pkg::rsp_t                         rsp
);

    logic signed [bspq_pkg::VALUE_W-1:0] slot_value_reg    [bspq_pkg::DEPTH];
    logic signed [bspq_pkg::VALUE_W-1:0] slot_value_next   [bspq_pkg::DEPTH];
    logic [bspq_pkg::PRIO_W-1:0]         slot_priority_reg [bspq_pkg::DEPTH];
    logic [bspq_pkg::PRIO_W-1:0]         slot_priority_next[bspq_pkg::DEPTH];
    logic [bspq_pkg::DEPTH-1:0]          keep;
    logic [bspq_pkg::CNT_W-1:0]          count_reg;
    logic [bspq_pkg::CNT_W-1:0]          count_next;
    logic [bspq_pkg::LIMIT_W-1:0]        limit_reg;
    bspq_pkg::rsp_t                      result_reg;
    bspq_pkg::rsp_t                      result_next;

    // a held slot stays put when its priority is at least the new one
    always_comb
    begin
        for (int i = 0; i < bspq_pkg::DEPTH; i++)
        begin
            keep[i] = (bspq_pkg::CNT_W'(i) < count_reg) &&
                      (slot_priority_reg[i] >= req.item_priority);
        end
    end

    genvar g;
    generate
        for (g = 0; g < bspq_pkg::DEPTH; g++)
        begin : g_slot
            logic take_new;
            logic signed [bspq_pkg::VALUE_W-1:0] below_value;
            logic [bspq_pkg::PRIO_W-1:0]         below_priority;
            logic signed [bspq_pkg::VALUE_W-1:0] above_value;
            logic [bspq_pkg::PRIO_W-1:0]         above_priority;

            if (g == 0)
            begin : g_first
                assign take_new       = !keep[g];
                assign above_value    = slot_value_reg[g];
                assign above_priority = slot_priority_reg[g];
            end
            else
            begin : g_rest
                assign take_new       = !keep[g] && keep[g-1];
                assign above_value    = slot_value_reg[g-1];
                assign above_priority = slot_priority_reg[g-1];
            end

            if (g == bspq_pkg::DEPTH - 1)
            begin : g_last
                assign below_value    = slot_value_reg[g];
                assign below_priority = slot_priority_reg[g];
            end
            else
            begin : g_inner
                assign below_value    = slot_value_reg[g+1];
                assign below_priority = slot_priority_reg[g+1];
            end

            always_comb
            begin
                slot_value_next[g]    = slot_value_reg[g];
                slot_priority_next[g] = slot_priority_reg[g];
                if (dp_cmd.enq && !keep[g])
                begin
                    if (take_new)
                    begin
                        slot_value_next[g]    = req.item_value;
                        slot_priority_next[g] = req.item_priority;
                    end
                    else
                    begin
                        slot_value_next[g]    = above_value;
                        slot_priority_next[g] = above_priority;
                    end
                end
                else if (dp_cmd.deq)
                begin
                    slot_value_next[g]    = below_value;
                    slot_priority_next[g] = below_priority;
                end
            end

            always_ff @(posedge clk)
            begin
                slot_value_reg[g]    <= slot_value_next[g];
                slot_priority_reg[g] <= slot_priority_next[g];
            end
        end
    endgenerate

    // full at the lower of the limit and the depth
    assign dp_status.full  = (bspq_pkg::CMP_W'(count_reg) >= bspq_pkg::CMP_W'(limit_reg)) ||
                             (bspq_pkg::CMP_W'(count_reg) >= bspq_pkg::CMP_W'(bspq_pkg::DEPTH));
    assign dp_status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (dp_cmd.enq)
        begin
            count_next = count_reg + bspq_pkg::CNT_W'(1);
        end
        else if (dp_cmd.deq)
        begin
            count_next = count_reg - bspq_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        result_next.status     = bspq_pkg::ST_DONE;
        result_next.head_value = '0;
        result_next.occupancy  = bspq_pkg::OCC_W'(count_next);
        if (dp_cmd.overflow)
        begin
            result_next.status = bspq_pkg::ST_OVERFLOW;
        end
        else if (dp_cmd.underflow)
        begin
            result_next.status     = bspq_pkg::ST_UNDERFLOW;
            result_next.head_value = bspq_pkg::MOST_NEGATIVE;
        end
        else if (dp_cmd.deq)
        begin
            result_next.head_value = slot_value_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            limit_reg <= bspq_pkg::LIMIT_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    assign rsp = result_reg;

endmodule

/* rtl/bounded_sorted_priority_queue_core.sv */
// top level of the bounded sorted priority queue
`timescale 1ns / 1ps

// Holds up to DEPTH (16) data/priority entries, sorted highest priority first, equal
// priorities in arrival order. Each request is an enqueue or a dequeue and gives exactly
// one result. For each request every slot compares its priority with the new one in
// parallel and shifts in a single step, and the result sits in an output register
// from the next cycle until its transfer. A new request is taken once that result has
// gone. queue_limit (cfg_data, reset 16) caps the occupancy; write it only while idle.

module bounded_sorted_priority_queue_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bspq_pkg::LIMIT_W-1:0]  cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bspq_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bspq_pkg::rsp_t                rsp
);

    bspq_pkg::dp_cmd_t    dp_cmd;
    bspq_pkg::dp_status_t dp_status;

    bspq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (req.operation),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    bspq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req       (req),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .rsp       (rsp)
    );

endmodule

/* dv/bounded_sorted_priority_queue_core_tb.sv */
// self-checking testbench for the bounded sorted priority queue core
`timescale 1ns / 1ps

module bounded_sorted_priority_queue_core_tb;

    import bspq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 80;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [LIMIT_W-1:0]   cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;

    bounded_sorted_priority_queue_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // shadow copy of the queue contents and limit
    logic signed [VALUE_W-1:0] shadow_value [DEPTH];
    logic [PRIO_W-1:0]         shadow_prio [DEPTH];
    int                        shadow_count = 0;
    logic [LIMIT_W-1:0]        shadow_limit = LIMIT_RESET;

    req_t request_backlog [$];
    rsp_t predicted_results [$];

    logic req_fire = 1'b0;
    int   req_count = 0;
    int   rsp_count = 0;
    int   fail_count = 0;
    int   cycle_count = 0;
    int   n_enq_done = 0;
    int   n_deq_done = 0;
    int   n_overflow = 0;
    int   n_underflow = 0;
    int   n_input_stalled = 0;
    int   n_limit_writes = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic calm;
    rsp_t want;

    // a stretch of the run with neither side idling
    assign calm = (req_count >= 650) && (req_count < 800);

    function automatic rsp_t sorted_queue_step(input req_t r);
        rsp_t res;
        int   pos;
        int   cap;
        int   i;
        res.status = ST_DONE;
        res.head_value = '0;
        cap = (int'(shadow_limit) < DEPTH) ? int'(shadow_limit) : DEPTH;
        if (r.operation == OP_ENQUEUE)
        begin
            if (shadow_count >= cap)
            begin
                res.status = ST_OVERFLOW;
                n_overflow++;
            end
            else
            begin
                // new entry goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= r.item_priority)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i] = shadow_prio[i-1];
                end
                shadow_value[pos] = r.item_value;
                shadow_prio[pos] = r.item_priority;
                shadow_count++;
                n_enq_done++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                res.status = ST_UNDERFLOW;
                res.head_value = MOST_NEGATIVE;
                n_underflow++;
            end
            else
            begin
                res.head_value = shadow_value[0];
                for (i = 1; i < shadow_count; i++)
                begin
                    shadow_value[i-1] = shadow_value[i];
                    shadow_prio[i-1] = shadow_prio[i];
                end
                shadow_count--;
                n_deq_done++;
            end
        end
        res.occupancy = OCC_W'(shadow_count);
        return res;
    endfunction

    // request side: predict on every transfer, track limit writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_limit = LIMIT_RESET;
            req_fire <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                shadow_limit = cfg_data;
            if (req_valid && req_stall)
                n_input_stalled++;
            req_fire <= req_valid && !req_stall;
            if (req_valid && !req_stall)
            begin
                predicted_results.push_back(sorted_queue_step(req));
                req_count++;
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_fire))
        begin
            if (request_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 19))
            begin
                req <= request_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result side stall, with one long hold-off so the input backs up
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && req_count >= 400 && request_backlog.size() > 20)
        begin
            rsp_stall <= 1'b1;
            hold_left <= 80;
            hold_done <= 1'b1;
        end
        else
            rsp_stall <= !calm && ($urandom_range(0, 99) < 19);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsp_count++;
            if (predicted_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d value %0d occupancy %0d",
                             rsp.status, rsp.head_value, rsp.occupancy);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (rsp.status !== want.status || rsp.head_value !== want.head_value ||
                    rsp.occupancy !== want.occupancy)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d mismatch: status %0d/%0d value %0d/%0d occ %0d/%0d",
                                 rsp_count, want.status, rsp.status, want.head_value,
                                 rsp.head_value, want.occupancy, rsp.occupancy);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", predicted_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_item(input op_t op, input logic signed [VALUE_W-1:0] value,
                            input logic [PRIO_W-1:0] prio);
        req_t r;
        r.operation = op;
        r.item_value = value;
        r.item_priority = prio;
        request_backlog.push_back(r);
    endtask

    // wait until every queued request has gone and every result has come back
    task automatic drain_and_wait();
        while (request_backlog.size() != 0 || req_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain_and_wait();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        n_limit_writes++;
    endtask

    task automatic random_phase(input int count, input int fill_pct, input int drain_pct);
        int   pct;
        int   pick;
        op_t  op;
        logic [PRIO_W-1:0] prio;
        for (int n = 0; n < count; n++)
        begin
            pct = (n < count / 2) ? fill_pct : drain_pct;
            op = ($urandom_range(0, 99) < pct) ? OP_ENQUEUE : OP_DEQUEUE;
            // mostly a few priorities so that ties are common
            pick = $urandom_range(0, 9);
            if (pick < 5)
                prio = PRIO_W'($urandom_range(0, 3));
            else if (pick < 7)
                prio = $urandom_range(0, 1) ? '1 : '0;
            else
                prio = PRIO_W'($urandom_range(0, 255));
            add_item(op, $urandom, prio);
        end
    endtask

    logic [LIMIT_W-1:0] phase_limit [14] = '{5'd31, 5'd16, 5'd1, 5'd8, 5'd0, 5'd17, 5'd5,
                                             5'd16, 5'd30, 5'd12, 5'd21, 5'd3, 5'd16, 5'd2};

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // underflow, extreme values and priorities, arrival order among ties
        add_item(OP_DEQUEUE, 32'sd0, 8'd0);
        add_item(OP_ENQUEUE, 32'sh7fffffff, 8'd255);
        add_item(OP_ENQUEUE, MOST_NEGATIVE, 8'd0);
        add_item(OP_ENQUEUE, -32'sd1, 8'd7);
        add_item(OP_ENQUEUE, 32'sd1, 8'd7);
        add_item(OP_ENQUEUE, 32'sd2, 8'd7);
        add_item(OP_ENQUEUE, 32'sd0, 8'd128);
        repeat (7) add_item(OP_DEQUEUE, -32'sd1, 8'd255);
        for (int k = 0; k < 6; k++)
            add_item(OP_ENQUEUE, 32'sd100 + k, (k == 2) ? 8'd200 : (k == 4) ? 8'd255 : 8'd5);

        // limit lowered below the current occupancy
        write_limit(5'd3);
        add_item(OP_ENQUEUE, 32'sd7, 8'd9);
        repeat (3) add_item(OP_DEQUEUE, 32'sd0, 8'd0);
        add_item(OP_ENQUEUE, 32'sd8, 8'd9);
        add_item(OP_DEQUEUE, 32'sd0, 8'd0);
        add_item(OP_ENQUEUE, 32'sd9, 8'd9);

        // zero limit: enqueue always overflows, held entries still drain
        write_limit(5'd0);
        add_item(OP_ENQUEUE, 32'sd10, 8'd1);
        repeat (4) add_item(OP_DEQUEUE, 32'sd0, 8'd0);

        for (int p = 0; p < 14; p++)
        begin
            write_limit(phase_limit[p]);
            random_phase(PHASE_ITEMS, 75, (p % 2) ? 70 : 25);
        end

        drain_and_wait();
        repeat (10) @(posedge clk);

        $display("%0d requests, %0d results over %0d limit settings; %0d cycles of input stall",
                 req_count, rsp_count, n_limit_writes, n_input_stalled);
        $display("enqueued %0d, dequeued %0d, overflows %0d, underflows %0d, mismatches %0d",
                 n_enq_done, n_deq_done, n_overflow, n_underflow, fail_count);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
